// ===== rtl/core/tcc_pkg.sv =====
// Shared types, codes and color tables for the text console block.
// Depends on nothing; the top level uses it by scoped names.
`default_nettype none

package tcc_pkg;

	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_BKSP  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		EV_DRAW    = 2'd0,
		EV_ERASE   = 2'd1,
		EV_REFRESH = 2'd2,
		EV_READ    = 2'd3
	} ev_t;

	localparam logic [7:0]  CH_LF     = 8'h0A;
	localparam logic [7:0]  CH_CR     = 8'h0D;
	localparam logic [23:0] RGB_ERASE = 24'h1A1A1A;

	typedef struct packed {
		ev_t         kind;
		logic [9:0]  px;
		logic [8:0]  py;
		logic [7:0]  glyph;
		logic [7:0]  attr;
		logic [23:0] rgb;
		logic        last;
	} res_t;

	function automatic logic [23:0] full_rgb(input logic [3:0] idx);
		logic [23:0] c;
		case (idx)
			4'h0: c = 24'h000000;
			4'h1: c = 24'h0000AA;
			4'h2: c = 24'h00AA00;
			4'h3: c = 24'h00AAAA;
			4'h4: c = 24'hAA0000;
			4'h5: c = 24'hAA00AA;
			4'h6: c = 24'hAA5500;
			4'h7: c = 24'hAAAAAA;
			4'h8: c = 24'h555555;
			4'h9: c = 24'h5555FF;
			4'hA: c = 24'h55FF55;
			4'hB: c = 24'h55FFFF;
			4'hC: c = 24'hFF5555;
			4'hD: c = 24'hFF55FF;
			4'hE: c = 24'hFFFF55;
			default: c = 24'hFFFFFF;
		endcase
		return c;
	endfunction

	// Reduced redraw palette: unlisted codes fall back to light gray.
	function automatic logic [23:0] reduced_rgb(input logic [3:0] idx);
		logic [23:0] c;
		case (idx)
			4'h0: c = 24'h000000;
			4'hA: c = 24'h55FF55;
			4'hB: c = 24'h55FFFF;
			4'hC: c = 24'hFF5555;
			4'hE: c = 24'hFFFF55;
			4'hF: c = 24'hFFFFFF;
			default: c = 24'hAAAAAA;
		endcase
		return c;
	endfunction

	function automatic logic [9:0] pix_x(input logic [6:0] col);
		logic [10:0] t;
		t = 11'(col) * 11'd9 + 11'd5;
		return t[9:0];
	endfunction

	function automatic logic [8:0] pix_y(input logic [5:0] row);
		logic [9:0] t;
		t = 10'(row) * 10'd12 + 10'd30;
		return t[8:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tcc_cmd_if.sv =====
// Command channel of the text console: valid/ready plus one command beat.
// No dependencies.
`default_nettype none

interface tcc_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] char_code;
	logic [7:0] color_attr;
	logic [5:0] read_row;
	logic [6:0] read_col;

	modport source (output valid, opcode, char_code, color_attr, read_row, read_col,
		input ready);
	modport sink (input valid, opcode, char_code, color_attr, read_row, read_col,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tcc_evt_if.sv =====
// Event channel of the text console: valid/ready plus one result beat.
// No dependencies.
`default_nettype none

interface tcc_evt_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_kind;
	logic [9:0]  pixel_x;
	logic [8:0]  pixel_y;
	logic [7:0]  glyph;
	logic [7:0]  attr_out;
	logic [23:0] rgb;
	logic        last;

	modport source (output valid, event_kind, pixel_x, pixel_y, glyph, attr_out, rgb, last,
		input ready);
	modport sink (input valid, event_kind, pixel_x, pixel_y, glyph, attr_out, rgb, last,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tcc_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module tcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [AW-1:0]            waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [AW-1:0]            raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

`default_nettype wire

// ===== rtl/core/text_console_cursor_scroll.sv =====
// Text console top level: cursor, character/attribute grid in RAM, scroll engine.
// Depends on tcc_pkg, tcc_cmd_if, tcc_evt_if and tcc_ram.
`default_nettype none

// Channel  Dir  Beat contents
// -------  ---  --------------------------------------------------------------
// cmd      in   opcode, char_code, color_attr, read_row, read_col
// evt      out  event_kind, pixel_x, pixel_y, glyph, attr_out, rgb, last
//
// Steps: put or backspace is accepted, then loads its result; read is accepted
// with the RAM read, captures the cell, then loads its result; a newline
// without scroll is done at acceptance. Scroll and clear each walk the grid
// once, one cell per cycle.
// Reset: after arst_n releases, an init pass writes zero to all ROWS*COLS
// cells (2849 at the defaults); cmd.ready stays low.
// Stalls: a held evt beat blocks only the next result load; the result
// register lets a new command be taken while the last beat still waits.

module text_console_cursor_scroll #(
	parameter int COLS = 77,
	parameter int ROWS = 37
) (
	input wire logic clk,
	input wire logic arst_n,
	tcc_cmd_if.sink  cmd,
	tcc_evt_if.source evt
);
	localparam int CW    = $clog2(COLS);
	localparam int RW    = $clog2(ROWS);
	localparam int AW    = CW + RW;
	localparam int DEPTH = ROWS * (2 ** CW);

	localparam logic [CW-1:0] COL_LAST = CW'(COLS - 1);
	localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
	localparam logic [RW-1:0] ROW_SCR  = RW'(ROWS - 2);
	localparam logic [6:0]    ROWS_W   = 7'(ROWS);
	localparam logic [7:0]    COLS_W   = 8'(COLS);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_EMIT,
		ST_CLEAR,
		ST_SCROLL
	} state_t;

	state_t state_q;
	state_t after_q;

	logic [CW-1:0] cur_col_q;
	logic [RW-1:0] cur_row_q;
	logic [CW-1:0] sw_col_q;
	logic [RW-1:0] sw_row_q;

	// Sweep write stage: in the cycle after the sweep read, so copy data is back.
	logic          s1_valid_s1;
	logic [AW-1:0] s1_addr_s1;
	logic          s1_copy_s1;
	logic          s1_attr_we_s1;

	tcc_pkg::res_t pend_q;
	tcc_pkg::res_t out_q;
	logic          out_valid_q;

	// RAM ports
	logic          c_we, a_we, rd_en;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    c_wd, a_wd, c_rd, a_rd;

	// Decode
	tcc_pkg::op_t  op;
	logic          acc;
	logic          is_nl;
	logic          rd_in_range;
	logic [CW-1:0] col_inc, col_dec;
	logic [RW-1:0] row_inc;
	logic          wrap, scr;
	logic          sweeping, sw_done, sw_copy;
	logic          out_free, out_load;

	assign op          = tcc_pkg::op_t'(cmd.opcode);
	assign cmd.ready   = (state_q == ST_IDLE) && !s1_valid_s1;
	assign acc         = cmd.valid && cmd.ready;
	assign is_nl       = (cmd.char_code == tcc_pkg::CH_LF) || (cmd.char_code == tcc_pkg::CH_CR);
	assign rd_in_range = ({1'b0, cmd.read_row} < ROWS_W) && ({1'b0, cmd.read_col} < COLS_W);

	// Cursor stays below COL_LAST and ROW_LAST, so these never overflow.
	assign col_inc = CW'(cur_col_q + 1'b1);
	assign col_dec = CW'(cur_col_q - 1'b1);
	assign row_inc = RW'(cur_row_q + 1'b1);
	assign wrap    = (col_inc == COL_LAST);
	assign scr     = (row_inc == ROW_LAST);

	assign sweeping = (state_q == ST_INIT) || (state_q == ST_CLEAR) || (state_q == ST_SCROLL);
	assign sw_done  = (sw_col_q == COL_LAST) && (sw_row_q == ROW_LAST);
	// Scroll copies rows up; on the last row it only clears characters.
	assign sw_copy  = (state_q == ST_SCROLL) && (sw_row_q != ROW_LAST);

	assign out_free = !out_valid_q || evt.ready;
	assign out_load = (state_q == ST_EMIT) && out_free;

	// Read port: sweep source row during scroll, else the requested cell.
	always_comb begin
		rd_en = 1'b0;
		raddr = {cmd.read_row[RW-1:0], cmd.read_col[CW-1:0]};
		if (state_q == ST_SCROLL) begin
			rd_en = sw_copy;
			raddr = {RW'(sw_row_q + 1'b1), sw_col_q};
		end else if (acc && (op == tcc_pkg::OP_READ) && rd_in_range) begin
			rd_en = 1'b1;
		end
	end

	// Write port: the sweep stage owns it; commands only write when it is idle.
	always_comb begin
		c_we  = 1'b0;
		a_we  = 1'b0;
		waddr = s1_addr_s1;
		c_wd  = '0;
		a_wd  = '0;
		if (s1_valid_s1) begin
			c_we = 1'b1;
			a_we = s1_attr_we_s1;
			c_wd = s1_copy_s1 ? c_rd : 8'h00;
			a_wd = s1_copy_s1 ? a_rd : 8'h00;
		end else if (acc && (op == tcc_pkg::OP_PUT) && !is_nl) begin
			c_we  = 1'b1;
			a_we  = 1'b1;
			waddr = {cur_row_q, cur_col_q};
			c_wd  = cmd.char_code;
			a_wd  = cmd.color_attr;
		end else if (acc && (op == tcc_pkg::OP_BKSP) && (cur_col_q != '0)) begin
			// Erase the character only; the attribute stays.
			c_we  = 1'b1;
			waddr = {cur_row_q, col_dec};
		end
	end

	tcc_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_chars (
		.clk   (clk),
		.we    (c_we),
		.waddr (waddr),
		.wdata (c_wd),
		.re    (rd_en),
		.raddr (raddr),
		.rdata (c_rd)
	);

	tcc_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_attrs (
		.clk   (clk),
		.we    (a_we),
		.waddr (waddr),
		.wdata (a_wd),
		.re    (rd_en),
		.raddr (raddr),
		.rdata (a_rd)
	);

	// Control: state, cursor, sweep counters and the result-valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			after_q     <= ST_IDLE;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			sw_col_q    <= '0;
			sw_row_q    <= '0;
			s1_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (evt.ready)
				out_valid_q <= 1'b0;

			s1_valid_s1 <= sweeping;

			// Advance the sweep raster; it lands back at zero when done.
			if (sweeping) begin
				if (sw_col_q == COL_LAST) begin
					sw_col_q <= '0;
					sw_row_q <= (sw_row_q == ROW_LAST) ? '0 : RW'(sw_row_q + 1'b1);
				end else begin
					sw_col_q <= CW'(sw_col_q + 1'b1);
				end
			end

			case (state_q)
				ST_INIT: begin
					if (sw_done)
						state_q <= ST_IDLE;
				end
				ST_CLEAR, ST_SCROLL: begin
					if (sw_done) begin
						state_q <= ST_EMIT;
						after_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc) begin
						case (op)
							tcc_pkg::OP_PUT: begin
								if (is_nl) begin
									cur_col_q <= '0;
									if (scr) begin
										cur_row_q <= ROW_SCR;
										state_q   <= ST_SCROLL;
									end else begin
										cur_row_q <= row_inc;
									end
								end else begin
									state_q <= ST_EMIT;
									// Scroll after the draw beat when the wrap hits the bottom.
									after_q <= (wrap && scr) ? ST_SCROLL : ST_IDLE;
									if (wrap) begin
										cur_col_q <= '0;
										if (scr)
											cur_row_q <= ROW_SCR;
										else
											cur_row_q <= row_inc;
									end else begin
										cur_col_q <= col_inc;
									end
								end
							end
							tcc_pkg::OP_BKSP: begin
								if (cur_col_q != '0) begin
									cur_col_q <= col_dec;
									state_q   <= ST_EMIT;
									after_q   <= ST_IDLE;
								end
							end
							tcc_pkg::OP_CLEAR: begin
								cur_col_q <= '0;
								cur_row_q <= '0;
								state_q   <= ST_CLEAR;
							end
							default: begin
								after_q <= ST_IDLE;
								state_q <= rd_in_range ? ST_READ : ST_EMIT;
							end
						endcase
					end
				end
				ST_READ: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free)
						state_q <= after_q;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload: sweep write stage, pending result and the result register.
	always_ff @(posedge clk) begin
		s1_addr_s1    <= {sw_row_q, sw_col_q};
		s1_copy_s1    <= sw_copy;
		s1_attr_we_s1 <= (state_q == ST_INIT) || sw_copy;

		if (out_load)
			out_q <= pend_q;

		if (sweeping && sw_done && (state_q != ST_INIT)) begin
			pend_q <= '{kind: tcc_pkg::EV_REFRESH, px: 10'd0, py: 9'd0, glyph: 8'h00,
				attr: 8'h00, rgb: 24'h000000, last: 1'b1};
		end else if (state_q == ST_READ) begin
			pend_q.glyph <= c_rd;
			pend_q.attr  <= a_rd;
			pend_q.rgb   <= (c_rd != 8'h00) ? tcc_pkg::reduced_rgb(a_rd[3:0]) : 24'h000000;
		end else if (acc) begin
			case (op)
				tcc_pkg::OP_BKSP: begin
					pend_q.kind  <= tcc_pkg::EV_ERASE;
					pend_q.px    <= tcc_pkg::pix_x(7'(col_dec));
					pend_q.py    <= tcc_pkg::pix_y(6'(cur_row_q));
					pend_q.glyph <= 8'h00;
					pend_q.attr  <= 8'h00;
					pend_q.rgb   <= tcc_pkg::RGB_ERASE;
					pend_q.last  <= 1'b1;
				end
				tcc_pkg::OP_READ: begin
					// Hold the pixel now; the cell data arrives from RAM next cycle.
					pend_q <= '{kind: tcc_pkg::EV_READ,
						px: rd_in_range ? tcc_pkg::pix_x(cmd.read_col) : 10'd0,
						py: rd_in_range ? tcc_pkg::pix_y(cmd.read_row) : 9'd0,
						glyph: 8'h00, attr: 8'h00, rgb: 24'h000000, last: 1'b1};
				end
				default: begin
					pend_q.kind  <= tcc_pkg::EV_DRAW;
					pend_q.px    <= tcc_pkg::pix_x(7'(cur_col_q));
					pend_q.py    <= tcc_pkg::pix_y(6'(cur_row_q));
					pend_q.glyph <= cmd.char_code;
					pend_q.attr  <= cmd.color_attr;
					pend_q.rgb   <= tcc_pkg::full_rgb(cmd.color_attr[3:0]);
					// A refresh follows when this put wraps into a scroll.
					pend_q.last  <= !(wrap && scr);
				end
			endcase
		end
	end

	assign evt.valid      = out_valid_q;
	assign evt.event_kind = out_q.kind;
	assign evt.pixel_x    = out_q.px;
	assign evt.pixel_y    = out_q.py;
	assign evt.glyph      = out_q.glyph;
	assign evt.attr_out   = out_q.attr;
	assign evt.rgb        = out_q.rgb;
	assign evt.last       = out_q.last;

	// Cursor never reaches the last column or the last row.
	a_cursor_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_col_q < COL_LAST) && (cur_row_q < ROW_LAST))
		else $error("cursor left its legal range");

	// A command never competes with a pending sweep write.
	a_wport_free: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_s1 |-> !acc)
		else $error("command accepted while sweep write pending");

	// Copy writes only follow scroll reads.
	a_copy_src: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_s1 && s1_copy_s1) |-> $past(state_q == ST_SCROLL))
		else $error("copy write without a scroll read");

	// A refresh always closes the results of its command.
	a_refresh_last: assert property (@(posedge clk) disable iff (!arst_n)
		(evt.valid && (evt.event_kind == tcc_pkg::EV_REFRESH)) |-> evt.last)
		else $error("refresh beat without last");

	// A clear command starts the clear sweep in the next cycle.
	a_clear_start: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (op == tcc_pkg::OP_CLEAR)) |=> (state_q == ST_CLEAR))
		else $error("clear did not start its sweep");

endmodule

`default_nettype wire
